// ===== rtl/hash_key_value_table_defines.svh =====
// Assertion macros for the module that carries checks.
`ifndef HASH_KEY_VALUE_TABLE_DEFINES_SVH
`define HASH_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define HKVT_CHECK(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define HKVT_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/hkvt_pkg.sv =====
package hkvt_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF = 4;

  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } hkvt_in_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             status;
  } hkvt_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ROWRD,
    ST_KEYRD,
    ST_KEYCMP,
    ST_EXEC,
    ST_RESP
  } hkvt_state_t;

  // Address width for a store of n entries, never below one bit.
  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/hkvt_ram.sv =====
module hkvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [hkvt_pkg::addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [hkvt_pkg::addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hkvt_remainder.sv =====
module hkvt_remainder #(
  parameter int BUCKETS = hkvt_pkg::BUCKETS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [hkvt_pkg::KEY_W-1:0]            key,
  output logic                                  done,
  output logic [hkvt_pkg::addr_w(BUCKETS)-1:0]  rem
);

  localparam int BW     = hkvt_pkg::addr_w(BUCKETS);
  localparam int DIGITS = hkvt_pkg::KEY_W / 16;
  // Reciprocal of the bucket count, scaled by 2^32.
  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [31:0] DIVISOR = 32'(BUCKETS);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       phase_r, phase_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [hkvt_pkg::KEY_W-1:0] sh_r, sh_nxt;
  logic [BW-1:0]              rem_r, rem_nxt;
  logic [31:0]                quo_r, quo_nxt;
  logic [31:0]                part;
  logic [63:0]                prod;
  logic [31:0]                diff;

  // The key is reduced sixteen bits at a time, top digit first. Each digit goes through
  // a quotient estimate from the scaled reciprocal and then the remainder. The estimate is
  // never more than one too small, so one subtraction corrects it.
  always_comb begin
    part      = {16'(rem_r), sh_r[hkvt_pkg::KEY_W-1 -: 16]};
    prod      = 64'(part) * 64'(RECIP);
    diff      = part - 32'(64'(quo_r) * 64'(DIVISOR));
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    if (start && !busy_r) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = '0;
      sh_nxt    = key;
      rem_nxt   = '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        quo_nxt   = prod[63:32];
        phase_nxt = 1'b1;
      end else begin
        if (diff >= DIVISOR) begin
          rem_nxt = BW'(diff - DIVISOR);
        end else begin
          rem_nxt = BW'(diff);
        end
        sh_nxt    = {sh_r[hkvt_pkg::KEY_W-17:0], 16'd0};
        cnt_nxt   = cnt_r + 2'd1;
        phase_nxt = 1'b0;
        if (cnt_r == 2'(DIGITS - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/hash_key_value_table.sv =====
// Sequence per transaction: the bucket is hashed by the remainder unit in four digit steps,
// the valid row is read, then the ways are scanned one key read and compare at a time
// (one to WAYS ways, stopping at a hit), then the update, then the result into the output.
// A new transaction is accepted only once the last one has left for the output register; a
// result left unread holds the next one back. Reset: synchronous, active low. Afterwards a
// clearing pass writes every bucket's valid row, one row a cycle, before any input.
`include "hash_key_value_table_defines.svh"

module hash_key_value_table #(
  parameter int BUCKETS = hkvt_pkg::BUCKETS_DEF,
  parameter int WAYS    = hkvt_pkg::WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hkvt_pkg::hkvt_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hkvt_pkg::hkvt_out_t out_data
);

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int BW      = hkvt_pkg::addr_w(BUCKETS);
  localparam int WW      = hkvt_pkg::addr_w(WAYS);
  localparam int EW      = hkvt_pkg::addr_w(ENTRIES);

  // The sequencer and its registers. Control state takes reset; the request,
  // the bucket pointers and the captured value are payload and do not.
  hkvt_pkg::hkvt_state_t state_r, state_nxt;
  logic [BW-1:0]         clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  hkvt_pkg::hkvt_out_t   out_data_r, out_data_nxt;
  hkvt_pkg::hkvt_in_t    req_r, req_nxt;
  hkvt_pkg::hkvt_out_t   res_r, res_nxt;
  logic [BW-1:0]         bucket_r, bucket_nxt;
  logic [EW-1:0]         base_r, base_nxt;
  logic [EW-1:0]         idx_r, idx_nxt;
  logic [WW-1:0]         way_r, way_nxt;
  logic                  hit_r, hit_nxt;
  logic [hkvt_pkg::VAL_W-1:0] cap_r, cap_nxt;

  // Remainder unit handshake.
  logic          rem_start;
  logic          rem_done;
  logic [BW-1:0] rem_val;

  // Storage ports. The valid store is one row of WAYS bits per bucket; the
  // key and value stores hold one entry at bucket*WAYS + way.
  logic                       vld_we;
  logic [BW-1:0]              vld_waddr;
  logic [WAYS-1:0]            vld_wdata;
  logic [WAYS-1:0]            vrow;
  logic                       key_we;
  logic                       val_we;
  logic [EW-1:0]              ent_waddr;
  logic [hkvt_pkg::KEY_W-1:0] key_rdata;
  logic [hkvt_pkg::VAL_W-1:0] val_rdata;

  logic          key_hit;
  logic          free_any;
  logic [WW-1:0] free_way;

  // Terms used by the checks at the end.
  logic in_hash;
  logic set_miss_step;
  logic full_out;
  logic full_clean;

  hkvt_remainder #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .key   (in_data.key),
    .done  (rem_done),
    .rem   (rem_val)
  );

  // The valid row is read at the current bucket all the time, so it stays
  // put for the whole scan and for the update that follows it.
  hkvt_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (bucket_r),
    .rdata (vrow)
  );

  hkvt_ram #(
    .WIDTH (hkvt_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (ent_waddr),
    .wdata (req_r.key),
    .raddr (idx_r),
    .rdata (key_rdata)
  );

  // The value store is read beside the key store, so a get that hits has
  // its value in hand in the same cycle as the key compare.
  hkvt_ram #(
    .WIDTH (hkvt_pkg::VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (ent_waddr),
    .wdata (req_r.value),
    .raddr (idx_r),
    .rdata (val_rdata)
  );

  // The one 64-bit comparator, reused for every way of the bucket.
  assign key_hit = vrow[way_r] && (key_rdata == req_r.key);

  // Lowest free way of the current row.
  always_comb begin
    free_any = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        free_any = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  assign in_ready = (state_r == hkvt_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    bucket_nxt    = bucket_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    way_nxt       = way_r;
    hit_nxt       = hit_r;
    cap_nxt       = cap_r;
    rem_start     = 1'b0;
    vld_we        = 1'b0;
    vld_waddr     = bucket_r;
    vld_wdata     = vrow;
    key_we        = 1'b0;
    val_we        = 1'b0;
    ent_waddr     = idx_r;

    case (state_r)
      hkvt_pkg::ST_CLEAR: begin
        // Post-reset sweep: one bucket row cleared per cycle.
        vld_we    = 1'b1;
        vld_waddr = clr_r;
        vld_wdata = '0;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = hkvt_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + BW'(1);
        end
      end

      hkvt_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          rem_start = 1'b1;
          state_nxt = hkvt_pkg::ST_HASH;
        end
      end

      hkvt_pkg::ST_HASH: begin
        // The remainder unit runs its digit steps, then the done flag is seen here.
        if (rem_done) begin
          bucket_nxt = rem_val;
          state_nxt  = hkvt_pkg::ST_ROWRD;
        end
      end

      hkvt_pkg::ST_ROWRD: begin
        // The valid row read is under way; point the entry stores at way 0.
        base_nxt  = EW'(bucket_r * WAYS);
        idx_nxt   = EW'(bucket_r * WAYS);
        way_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = hkvt_pkg::ST_KEYRD;
      end

      hkvt_pkg::ST_KEYRD: begin
        state_nxt = hkvt_pkg::ST_KEYCMP;
      end

      hkvt_pkg::ST_KEYCMP: begin
        if (key_hit) begin
          // A key is held at most once, so the scan can stop here.
          hit_nxt   = 1'b1;
          cap_nxt   = val_rdata;
          state_nxt = hkvt_pkg::ST_EXEC;
        end else if (way_r == WW'(WAYS - 1)) begin
          state_nxt = hkvt_pkg::ST_EXEC;
        end else begin
          way_nxt   = way_r + WW'(1);
          idx_nxt   = idx_r + EW'(1);
          state_nxt = hkvt_pkg::ST_KEYRD;
        end
      end

      hkvt_pkg::ST_EXEC: begin
        // On a hit idx_r and way_r still point at the matching entry.
        res_nxt = '0;
        case (req_r.func)
          hkvt_pkg::FUNC_SET: begin
            if (hit_r) begin
              val_we        = 1'b1;
              res_nxt.found = 1'b1;
            end else if (free_any) begin
              key_we    = 1'b1;
              val_we    = 1'b1;
              ent_waddr = base_r + EW'(free_way);
              vld_we    = 1'b1;
              vld_wdata = vrow | (WAYS'(1) << free_way);
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          hkvt_pkg::FUNC_GET: begin
            if (hit_r) begin
              res_nxt.found      = 1'b1;
              res_nxt.read_value = cap_r;
            end
          end
          hkvt_pkg::FUNC_DEL: begin
            if (hit_r) begin
              res_nxt.found = 1'b1;
              vld_we        = 1'b1;
              vld_wdata     = vrow & ~(WAYS'(1) << way_r);
            end
          end
          default: begin
            // The unused code leaves the table alone and answers with zeros.
          end
        endcase
        state_nxt = hkvt_pkg::ST_RESP;
      end

      hkvt_pkg::ST_RESP: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = hkvt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hkvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hkvt_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    bucket_r   <= bucket_nxt;
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    way_r      <= way_nxt;
    hit_r      <= hit_nxt;
    cap_r      <= cap_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_hash       = (state_r == hkvt_pkg::ST_HASH);
  assign set_miss_step = !hit_r && (req_r.func == hkvt_pkg::FUNC_SET) &&
                         (state_r == hkvt_pkg::ST_EXEC);
  assign full_out      = out_valid && out_data.status;
  assign full_clean    = !out_data.found && (out_data.read_value == '0);

  // The remainder unit only finishes while the sequencer waits for it.
  `HKVT_CHECK(a_rem_done_in_hash, rem_done, in_hash, "remainder done outside hash wait")
  // A new key is written only by a set that missed, in the update step.
  `HKVT_CHECK(a_insert_on_miss, key_we, set_miss_step, "key written outside a set miss")
  // A full-bucket failure reports neither a hit nor a value.
  `HKVT_CHECK(a_full_is_clean, full_out, full_clean, "full status with found or value")
  // An accepted transaction always starts the bucket computation.
  `HKVT_CHECK_NEXT(a_accept_hashes, in_valid && in_ready, in_hash, "accept did not start hashing")

endmodule

// ===== test/hash_key_value_table_test.sv =====
module hash_key_value_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef hkvt_pkg::hkvt_in_t  hkvt_in_t;
  typedef hkvt_pkg::hkvt_out_t hkvt_out_t;

  localparam logic [1:0] FUNC_SET = hkvt_pkg::FUNC_SET;
  localparam logic [1:0] FUNC_GET = hkvt_pkg::FUNC_GET;
  localparam logic [1:0] FUNC_DEL = hkvt_pkg::FUNC_DEL;

  // The table geometry matches the block's defaults. Keys for random traffic are built as
  // an upper part over an 8-bit bucket index, which relies on 256 buckets.
  localparam int BUCKETS = hkvt_pkg::BUCKETS_DEF;
  localparam int WAYS    = hkvt_pkg::WAYS_DEF;
  localparam int ENTRIES = BUCKETS * WAYS;

  // The block ignores this code: it answers with an all-zero result and leaves the table alone.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  // Each transaction spends its time inside the block plus a random sender gap and receiver
  // stall, and the clearing pass runs after reset. This limit leaves a wide margin over the
  // whole correct run.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 826;
  localparam int PRINT_CAP    = 30;

  // One row of stimulus. Where typed is set, resp holds the result written down by hand;
  // otherwise the result comes from the shadow table below.
  typedef struct {
    hkvt_in_t  req;
    bit        typed;
    hkvt_out_t resp;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  hkvt_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hkvt_out_t out_data;

  hash_key_value_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Shadow copy of the table, updated in order of acceptance.
  bit          mirror_valid [ENTRIES];
  logic [63:0] mirror_key   [ENTRIES];
  logic [63:0] mirror_value [ENTRIES];

  stim_row_t stimulus[$];
  hkvt_out_t awaited_responses[$];

  // The row currently presented on the input channel; written at the falling edge.
  stim_row_t cur_row;

  int mismatch_count = 0;
  int checked_count  = 0;
  int set_count      = 0;
  int full_count     = 0;
  int get_count      = 0;
  int hit_count      = 0;
  int del_count      = 0;
  int unused_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result it must produce. Only
  // valid entries are compared, so entries that were never written are never looked at.
  function automatic hkvt_out_t apply_request(hkvt_in_t req);
    int        base;
    int        w;
    int        hit;
    int        free_way;
    hkvt_out_t resp;
    base     = int'(req.key % 64'(BUCKETS)) * WAYS;
    hit      = -1;
    free_way = -1;
    resp     = '0;
    for (w = 0; w < WAYS; w++) begin
      if (hit < 0 && mirror_valid[base + w] && mirror_key[base + w] == req.key) begin
        hit = w;
      end
      if (free_way < 0 && !mirror_valid[base + w]) begin
        free_way = w;
      end
    end
    case (req.func)
      FUNC_SET: begin
        if (hit >= 0) begin
          // A present key is overwritten in place, even when its bucket is full.
          resp.found = 1'b1;
          mirror_value[base + hit] = req.value;
        end else if (free_way >= 0) begin
          mirror_valid[base + free_way] = 1'b1;
          mirror_key[base + free_way]   = req.key;
          mirror_value[base + free_way] = req.value;
        end else begin
          // Bucket full: the set is refused and nothing is stored.
          resp.status = 1'b1;
        end
      end
      FUNC_GET: begin
        if (hit >= 0) begin
          resp.found      = 1'b1;
          resp.read_value = mirror_value[base + hit];
        end
      end
      FUNC_DEL: begin
        if (hit >= 0) begin
          resp.found = 1'b1;
          mirror_valid[base + hit] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [63:0] key, input logic [63:0] value,
                         input bit typed, input logic found, input logic [63:0] read_value,
                         input logic status);
    stim_row_t row;
    row.req.func        = func;
    row.req.key         = key;
    row.req.value       = value;
    row.typed           = typed;
    row.resp.found      = found;
    row.resp.read_value = read_value;
    row.resp.status     = status;
    stimulus.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  // Scoreboard. Every accepted request is turned into its expected result at the same edge,
  // and every accepted result is compared against the oldest one still awaited. The request
  // side is handled first so that a result can never overtake its own expectation.
  always @(posedge clk) begin : scoreboard
    hkvt_out_t predicted;
    hkvt_out_t want;
    if (rst_n && in_valid && in_ready) begin
      predicted = apply_request(in_data);
      case (in_data.func)
        FUNC_SET: begin
          set_count++;
          if (predicted.status) begin
            full_count++;
          end
        end
        FUNC_GET: begin
          get_count++;
          if (predicted.found) begin
            hit_count++;
          end
        end
        FUNC_DEL: del_count++;
        default:  unused_count++;
      endcase
      awaited_responses.push_back(cur_row.typed ? cur_row.resp : predicted);
    end
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (awaited_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end
      end else begin
        want = awaited_responses.pop_front();
        check_field("found", 64'(want.found), 64'(out_data.found));
        check_field("read_value", want.read_value, out_data.read_value);
        check_field("status", 64'(want.status), 64'(out_data.status));
      end
    end
  end

  // Receiver. For each result it draws a stall; with a nonzero stall it keeps ready low until
  // a result is on offer and then for the length of the stall, so that back pressure lands on
  // the result itself. Every fourth run of 40 results is taken with no stall at all.
  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = ((taken / 40) % 4 == 3) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (out_valid !== 1'b1) @(posedge clk);
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("hash_key_value_table: mismatch");
    $finish;
  end

  initial begin : sender
    logic [55:0] key_tops    [6];
    logic [7:0]  hot_buckets [8];
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] value;
    int          pick;
    int          counted;
    int          gap;
    int          idx;

    for (idx = 0; idx < ENTRIES; idx++) begin
      mirror_valid[idx] = 1'b0;
      mirror_key[idx]   = '0;
      mirror_value[idx] = '0;
    end

    // Directed part. Bucket 0 is filled with keys 0, 256, 512 and 768, which exposes a set
    // into a full bucket, an overwrite inside a full bucket and reuse of a freed way. The
    // extremes of the key and value ranges and the ignored function code follow.
    add_row(FUNC_GET,    64'd0,    64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_DEL,    ALL_ONES, 64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd0,    ALL_ONES, 1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_GET,    64'd0,    64'd0,    1, 1'b1, ALL_ONES, 1'b0);
    add_row(FUNC_SET,    64'd256,  64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd512,  64'd1,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd768,  64'd2,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd1024, 64'd3,    1, 1'b0, 64'd0,    1'b1);
    add_row(FUNC_GET,    64'd1024, 64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd0,    64'd0,    1, 1'b1, 64'd0,    1'b0);
    add_row(FUNC_GET,    64'd0,    ALL_ONES, 1, 1'b1, 64'd0,    1'b0);
    add_row(FUNC_DEL,    64'd256,  64'd0,    1, 1'b1, 64'd0,    1'b0);
    add_row(FUNC_DEL,    64'd256,  64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'd1024, 64'h0123_4567_89ab_cdef, 1, 1'b0, 64'd0, 1'b0);
    add_row(FUNC_GET,    64'd1024, 64'd0,    0, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_UNUSED, 64'd0,    ALL_ONES, 1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_GET,    64'd0,    64'd0,    0, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    ALL_ONES, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0, 64'd0, 1'b0);
    add_row(FUNC_GET,    ALL_ONES, 64'd0,    0, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_SET,    64'hffff_ffff_ffff_feff, 64'h5555_5555_5555_5555, 0, 1'b0, 64'd0, 1'b0);
    add_row(FUNC_DEL,    ALL_ONES, 64'd0,    1, 1'b1, 64'd0,    1'b0);
    add_row(FUNC_GET,    ALL_ONES, 64'd0,    1, 1'b0, 64'd0,    1'b0);
    add_row(FUNC_GET,    64'h7fff_ffff_ffff_ffff, 64'd0, 0, 1'b0, 64'd0, 1'b0);
    add_row(FUNC_GET,    64'hffff_ffff_ffff_feff, 64'd0, 0, 1'b0, 64'd0, 1'b0);

    // Random part. Most keys come from six upper parts over eight hot buckets, so buckets
    // fill up, overflow and drain again and gets and deletes mostly find their keys. A share
    // of fully random keys and values keeps every bit of both fields moving.
    for (idx = 0; idx < 6; idx++) begin
      key_tops[idx] = 56'({$urandom(), $urandom()});
    end
    key_tops[0] = '1;
    key_tops[1] = '0;
    hot_buckets[0] = 8'd0;
    hot_buckets[1] = 8'd255;
    for (idx = 2; idx < 8; idx++) begin
      hot_buckets[idx] = 8'($urandom_range(0, 255));
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        func = FUNC_SET;
      end else if (pick < 75) begin
        func = FUNC_GET;
      end else if (pick < 95) begin
        func = FUNC_DEL;
      end else begin
        func = FUNC_UNUSED;
      end
      if ($urandom_range(0, 99) < 15) begin
        key = {$urandom(), $urandom()};
      end else begin
        key = {key_tops[$urandom_range(0, 5)], hot_buckets[$urandom_range(0, 7)]};
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        value = '0;
      end else if (pick < 10) begin
        value = ALL_ONES;
      end else begin
        value = {$urandom(), $urandom()};
      end
      add_row(func, key, value, 0, 1'b0, 64'd0, 1'b0);
      counted++;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Each request waits a random gap before it is offered, except for every fourth run of
    // 48 requests, which goes back to back. Valid then holds until the block takes it.
    @(negedge clk);
    for (idx = 0; idx < stimulus.size(); idx++) begin
      gap = ((idx / 48) % 4 == 2) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      cur_row = stimulus[idx];
      in_data  <= stimulus[idx].req;
      in_valid <= 1'b1;
      @(posedge clk);
      while (in_ready !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    // Wait for the last results, then give the block time to show any stray one.
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d sets (%0d refused, bucket full), %0d gets (%0d hits),",
             checked_count, set_count, full_count, get_count, hit_count);
    $display("  %0d deletes and %0d requests with the unused function code.",
             del_count, unused_count);
    if (mismatch_count == 0) begin
      $display("hash_key_value_table: match");
    end else begin
      $display("hash_key_value_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hkvt_pkg.sv
rtl/hkvt_ram.sv
rtl/hkvt_remainder.sv
rtl/hash_key_value_table.sv
test/hash_key_value_table_test.sv
